@@ rtl/terminal_key_escape_decoder_top_assert.svh @@
// ---------------------------------------------------------------------------
// Terminal key escape decoder assertion macros
// Concurrent assertion helpers for the decoder top level. They expand to
// nothing when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef TERMINAL_KEY_ESCAPE_DECODER_TOP_ASSERT_SVH
`define TERMINAL_KEY_ESCAPE_DECODER_TOP_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on clk and disabled during reset.
`define TKED_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");
// Next-cycle implication, sampled on clk and disabled during reset.
`define TKED_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");
`else
`define TKED_ASSERT_IMP(lbl, ante, cons)
`define TKED_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

@@ rtl/tked_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Terminal key escape decoder package
// Parse phases, byte constants and key codes shared by the decoder.
// ---------------------------------------------------------------------------
package tked_pkg;

	// Parse phase of the escape sequence recogniser.
	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_ESC    = 3'd1,
		PH_LEAD   = 3'd2,
		PH_DIGIT  = 3'd3,
		PH_FOURTH = 3'd4,
		PH_SHARR  = 3'd5,
		PH_SRET   = 3'd6,
		PH_SRET_U = 3'd7
	} phase_t;

	typedef logic [7:0] byte_t;
	typedef logic [8:0] key_t;

	// Byte constants.
	localparam byte_t CH_ESC   = 8'd27;
	localparam byte_t CH_LBRK  = 8'h5B;
	localparam byte_t CH_O     = 8'h4F;
	localparam byte_t CH_TILDE = 8'h7E;
	localparam byte_t CH_SEMI  = 8'h3B;
	localparam byte_t CH_U     = 8'h75;
	localparam byte_t CH_0     = 8'h30;
	localparam byte_t CH_1     = 8'h31;
	localparam byte_t CH_2     = 8'h32;
	localparam byte_t CH_3     = 8'h33;
	localparam byte_t CH_5     = 8'h35;
	localparam byte_t CH_6     = 8'h36;
	localparam byte_t CH_9     = 8'h39;
	localparam byte_t CH_A     = 8'h41;
	localparam byte_t CH_D     = 8'h44;
	localparam byte_t CH_H     = 8'h48;
	localparam byte_t CH_F     = 8'h46;

	// Dense key codes.
	localparam key_t KEY_ESC          = 9'd27;
	localparam key_t KEY_UP           = 9'd256;
	localparam key_t KEY_HOME         = 9'd260;
	localparam key_t KEY_END          = 9'd261;
	localparam key_t KEY_DEL          = 9'd262;
	localparam key_t KEY_PGUP         = 9'd263;
	localparam key_t KEY_PGDN         = 9'd264;
	localparam key_t KEY_SHIFT_UP     = 9'd265;
	localparam key_t KEY_SHIFT_RETURN = 9'd269;
	localparam key_t KEY_MAX          = 9'd269;

endpackage

@@ rtl/terminal_key_escape_decoder_top.sv @@
// Each accepted input beat is held in the input register; its result is then
// written to the result register and presented to the output side.
// Throughput: one input beat per cycle whenever the output side takes results.
// The input register advances only when the result register is free or being
// drained, so a stalled output backs up one input beat and then holds in_ready low.
// Reset clears the parse phase, the saved sequence bytes and both valid flags.
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Terminal key escape decoder
// Turns terminal bytes and read timeouts into dense key codes, decoding
// cursor, editing and shifted escape sequences.
// ---------------------------------------------------------------------------
`include "terminal_key_escape_decoder_top_assert.svh"

module terminal_key_escape_decoder_top
	import tked_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] byte_value,
	input  logic       timed_out,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [8:0] key_code
);

	// Input register.
	logic   valid_s1;
	byte_t  byte_s1;
	logic   tick_s1;

	// Parse state.
	phase_t phase_q, phase_d;
	byte_t  lead_q, lead_d;
	byte_t  second_q, second_d;
	byte_t  third_q, third_d;
	byte_t  fourth_q, fourth_d;

	// Result register.
	logic   out_valid_q;
	key_t   key_q;

	logic   adv;
	logic   emit;
	key_t   code;
	logic   hit;
	key_t   dec_code;
	logic   is_digit;
	logic   is_arrow;
	logic [1:0] arrow_off;

	// The input beat is processed when the result slot is free or draining.
	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= byte_value;
			tick_s1 <= timed_out;
		end
	end

	// Byte classification of the current beat.
	assign is_digit  = (byte_s1 >= CH_0) && (byte_s1 <= CH_9);
	assign is_arrow  = (byte_s1 >= CH_A) && (byte_s1 <= CH_D);
	assign arrow_off = 2'(byte_s1 - CH_A);

	// Key decision for the phases that may complete a sequence.
	always_comb begin
		hit      = 1'b0;
		dec_code = KEY_UP;
		unique case (phase_q)
			PH_LEAD: begin
				if (lead_q == CH_LBRK) begin
					if (is_arrow) begin
						hit      = 1'b1;
						dec_code = KEY_UP + {7'd0, arrow_off};
					end
				end
				if ((lead_q == CH_LBRK) || (lead_q == CH_O)) begin
					if (byte_s1 == CH_H) begin
						hit      = 1'b1;
						dec_code = KEY_HOME;
					end
					if (byte_s1 == CH_F) begin
						hit      = 1'b1;
						dec_code = KEY_END;
					end
				end
			end
			PH_DIGIT: begin
				if (byte_s1 == CH_TILDE) begin
					if (second_q == CH_3) begin
						hit      = 1'b1;
						dec_code = KEY_DEL;
					end else if (second_q == CH_5) begin
						hit      = 1'b1;
						dec_code = KEY_PGUP;
					end else if (second_q == CH_6) begin
						hit      = 1'b1;
						dec_code = KEY_PGDN;
					end
				end
			end
			PH_SHARR: begin
				if ((second_q == CH_1) && (fourth_q == CH_2) && is_arrow) begin
					hit      = 1'b1;
					dec_code = KEY_SHIFT_UP + {7'd0, arrow_off};
				end
			end
			PH_SRET_U: begin
				if ((fourth_q == CH_2) && (byte_s1 == CH_U)) begin
					hit      = 1'b1;
					dec_code = KEY_SHIFT_RETURN;
				end
			end
			default: begin
				hit      = 1'b0;
				dec_code = KEY_UP;
			end
		endcase
	end

	// Next phase and saved sequence bytes.
	always_comb begin
		phase_d  = phase_q;
		lead_d   = lead_q;
		second_d = second_q;
		third_d  = third_q;
		fourth_d = fourth_q;
		if (tick_s1) begin
			phase_d = PH_IDLE;
		end else begin
			unique case (phase_q)
				PH_IDLE: begin
					if (byte_s1 == CH_ESC) phase_d = PH_ESC;
				end
				PH_ESC: begin
					lead_d  = byte_s1;
					phase_d = PH_LEAD;
				end
				PH_LEAD: begin
					if ((lead_q == CH_LBRK) && is_digit) begin
						second_d = byte_s1;
						phase_d  = PH_DIGIT;
					end else begin
						phase_d = hit ? PH_IDLE : PH_ESC;
					end
				end
				PH_DIGIT: begin
					if (byte_s1 == CH_TILDE) begin
						phase_d = hit ? PH_IDLE : PH_ESC;
					end else if ((byte_s1 == CH_SEMI) ||
					             ((second_q == CH_1) && (byte_s1 == CH_3))) begin
						third_d = byte_s1;
						phase_d = PH_FOURTH;
					end else begin
						phase_d = PH_ESC;
					end
				end
				PH_FOURTH: begin
					if (third_q == CH_SEMI) begin
						fourth_d = byte_s1;
						phase_d  = PH_SHARR;
					end else if (byte_s1 == CH_SEMI) begin
						fourth_d = byte_s1;
						phase_d  = PH_SRET;
					end else begin
						phase_d = PH_ESC;
					end
				end
				PH_SRET: begin
					fourth_d = byte_s1;
					phase_d  = PH_SRET_U;
				end
				PH_SHARR, PH_SRET_U: begin
					phase_d = hit ? PH_IDLE : PH_ESC;
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	// Result of the current beat.
	always_comb begin
		emit = 1'b0;
		code = KEY_ESC;
		if (tick_s1) begin
			emit = (phase_q != PH_IDLE);
			code = KEY_ESC;
		end else if (phase_q == PH_IDLE) begin
			emit = (byte_s1 != CH_ESC);
			code = {1'b0, byte_s1};
		end else begin
			emit = hit;
			code = dec_code;
		end
	end

	// Parse state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			lead_q   <= '0;
			second_q <= '0;
			third_q  <= '0;
			fourth_q <= '0;
		end else if (adv) begin
			phase_q  <= phase_d;
			lead_q   <= lead_d;
			second_q <= second_d;
			third_q  <= third_d;
			fourth_q <= fourth_d;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= emit;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			key_q <= code;
		end
	end

	assign out_valid = out_valid_q;
	assign key_code  = key_q;

	// A timeout while idle leaves no result behind.
	`TKED_ASSERT_NXT(a_idle_tick_silent, adv && tick_s1 && (phase_q == PH_IDLE), !out_valid)
	// A timeout inside a sequence yields a lone escape.
	`TKED_ASSERT_NXT(a_tick_esc, adv && tick_s1 && phase_q != PH_IDLE, out_valid && key_code == KEY_ESC)
	// Delivered key codes stay within the defined range.
	`TKED_ASSERT_IMP(a_code_range, out_valid, key_code <= KEY_MAX)
	// A held input beat blocks new input.
	`TKED_ASSERT_IMP(a_hold_blocks, valid_s1 && !adv, !in_ready)

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Terminal key escape decoder testbench
// Feeds terminal bytes and read timeouts into the decoder through its
// valid/ready input and compares every key code that it produces with a
// behavioural decoder kept in a small tracker class. Directed sequences come
// first, then random well-formed, truncated and corrupted escape sequences
// mixed with plain bytes, with random idling, a long output hold-off and a
// full drain pause.
// ---------------------------------------------------------------------------
module tb;
	import tked_pkg::*;

	localparam int MAX_GAP     = 13;
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 3000;

	typedef struct packed {
		logic  tick;
		byte_t value;
	} key_beat_t;

	// Behavioural decoder and the queue of key codes it still expects.
	class key_code_tracker;
		phase_t phase;
		byte_t  seq_lead;
		byte_t  seq_second;
		byte_t  seq_third;
		byte_t  seq_fourth;
		key_t   expected_keys[$];
		int     errors;
		int     beats_seen;
		int     keys_checked;
		int     special_keys;

		function new();
			phase        = PH_IDLE;
			seq_lead     = '0;
			seq_second   = '0;
			seq_third    = '0;
			seq_fourth   = '0;
			errors       = 0;
			beats_seen   = 0;
			keys_checked = 0;
			special_keys = 0;
		endfunction

		// A final letter A to D selects one of four codes from the base.
		function key_t arrow_key(byte_t b, key_t base);
			if (b >= CH_A && b <= CH_D)
				return base + key_t'(b - CH_A);
			return '0;
		endfunction

		// Advances the decoder by one accepted input beat.
		function void note_beat(byte_t b, logic tick);
			key_t code;
			code = '0;
			beats_seen++;

			// A timeout only matters inside a sequence, where it yields a lone escape.
			if (tick) begin
				if (phase != PH_IDLE) begin
					phase = PH_IDLE;
					expected_keys.push_back(KEY_ESC);
				end
				return;
			end

			case (phase)
				PH_IDLE: begin
					if (b == CH_ESC)
						phase = PH_ESC;
					else
						expected_keys.push_back({1'b0, b});
					return;
				end
				PH_ESC: begin
					seq_lead = b;
					phase    = PH_LEAD;
					return;
				end
				PH_LEAD: begin
					if (seq_lead == CH_LBRK) begin
						if (b >= CH_0 && b <= CH_9) begin
							seq_second = b;
							phase      = PH_DIGIT;
							return;
						end
						code = arrow_key(b, KEY_UP);
						if (b == CH_H) code = KEY_HOME;
						if (b == CH_F) code = KEY_END;
					end else if (seq_lead == CH_O) begin
						if (b == CH_H) code = KEY_HOME;
						if (b == CH_F) code = KEY_END;
					end
				end
				PH_DIGIT: begin
					if (b == CH_TILDE) begin
						if (seq_second == CH_3)
							code = KEY_DEL;
						else if (seq_second == CH_5)
							code = KEY_PGUP;
						else if (seq_second == CH_6)
							code = KEY_PGDN;
					end else if (b == CH_SEMI || (seq_second == CH_1 && b == CH_3)) begin
						seq_third = b;
						phase     = PH_FOURTH;
						return;
					end
				end
				PH_FOURTH: begin
					if (seq_third == CH_SEMI) begin
						seq_fourth = b;
						phase      = PH_SHARR;
						return;
					end
					if (b == CH_SEMI) begin
						seq_fourth = b;
						phase      = PH_SRET;
						return;
					end
				end
				PH_SHARR: begin
					if (seq_second == CH_1 && seq_fourth == CH_2)
						code = arrow_key(b, KEY_SHIFT_UP);
				end
				PH_SRET: begin
					seq_fourth = b;
					phase      = PH_SRET_U;
					return;
				end
				default: begin
					if (seq_fourth == CH_2 && b == CH_U)
						code = KEY_SHIFT_RETURN;
				end
			endcase

			// A recognised key ends the sequence; anything else restarts after an escape.
			if (code != '0) begin
				phase = PH_IDLE;
				expected_keys.push_back(code);
			end else begin
				phase = PH_ESC;
			end
		endfunction

		// Compares one accepted output beat with the oldest expected key code.
		function void check_key(key_t got);
			key_t want;
			keys_checked++;
			if (got >= KEY_UP)
				special_keys++;
			if (expected_keys.size() == 0) begin
				$error("key_code: unexpected result, expected none, actual %0d", got);
				errors++;
				return;
			end
			want = expected_keys.pop_front();
			if (got !== want) begin
				$error("key_code mismatch: expected %0d, actual %0d", want, got);
				errors++;
			end
		endfunction

		function int outstanding();
			return expected_keys.size();
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] byte_value;
	logic       timed_out;
	logic       out_valid;
	logic       out_ready;
	logic [8:0] key_code;

	key_code_tracker tracker;
	key_beat_t       stim_q[$];
	bit              tx_gaps_on   = 1'b1;
	bit              rx_gaps_on   = 1'b1;
	bit              hold_request = 1'b0;
	int              holds_done   = 0;

	terminal_key_escape_decoder_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.byte_value (byte_value),
		.timed_out  (timed_out),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.key_code   (key_code)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Stimulus builders.
	function automatic void push_beat(byte_t v, logic tick);
		key_beat_t beat;
		beat.value = v;
		beat.tick  = tick;
		stim_q.push_back(beat);
	endfunction

	function automatic byte_t any_byte();
		return byte_t'($urandom_range(0, 255));
	endfunction

	// Bytes that steer the decoder along its sequence paths.
	function automatic byte_t escape_alphabet_byte();
		case ($urandom_range(0, 16))
			0:       return CH_LBRK;
			1:       return CH_O;
			2:       return CH_TILDE;
			3:       return CH_SEMI;
			4:       return CH_U;
			5:       return CH_0;
			6:       return CH_1;
			7:       return CH_2;
			8:       return CH_3;
			9:       return CH_5;
			10:      return CH_6;
			11:      return CH_9;
			12:      return CH_A;
			13:      return CH_D;
			14:      return CH_H;
			15:      return CH_F;
			default: return CH_ESC;
		endcase
	endfunction

	// One recognised key sequence, sometimes cut short by a timeout or corrupted.
	function automatic void add_key_sequence();
		byte_t seq[$];
		int    r;
		int    cut;
		seq.push_back(CH_ESC);
		case ($urandom_range(0, 4))
			0: begin
				seq.push_back(CH_LBRK);
				r = $urandom_range(0, 5);
				seq.push_back(r < 4 ? byte_t'(CH_A + r) : (r == 4 ? CH_H : CH_F));
			end
			1: begin
				seq.push_back(CH_O);
				seq.push_back($urandom_range(0, 1) ? CH_H : CH_F);
			end
			2: begin
				seq.push_back(CH_LBRK);
				r = $urandom_range(0, 2);
				seq.push_back(r == 0 ? CH_3 : (r == 1 ? CH_5 : CH_6));
				seq.push_back(CH_TILDE);
			end
			3: begin
				seq.push_back(CH_LBRK);
				seq.push_back(CH_1);
				seq.push_back(CH_SEMI);
				seq.push_back(CH_2);
				seq.push_back(byte_t'(CH_A + $urandom_range(0, 3)));
			end
			default: begin
				seq.push_back(CH_LBRK);
				seq.push_back(CH_1);
				seq.push_back(CH_3);
				seq.push_back(CH_SEMI);
				seq.push_back(CH_2);
				seq.push_back(CH_U);
			end
		endcase

		r = $urandom_range(0, 9);
		if (r == 0) begin
			cut = $urandom_range(1, seq.size() - 1);
			for (int i = 0; i < cut; i++)
				push_beat(seq[i], 1'b0);
			push_beat(any_byte(), 1'b1);
		end else begin
			if (r == 1)
				seq[$urandom_range(1, seq.size() - 1)] = any_byte();
			foreach (seq[i])
				push_beat(seq[i], 1'b0);
		end
	endfunction

	// Mostly well-formed sequences, the rest plain bytes, timeouts and noise.
	function automatic void gen_random(int count);
		int start;
		int r;
		start = stim_q.size();
		while (stim_q.size() - start < count) begin
			r = $urandom_range(0, 99);
			if (r < 55) begin
				add_key_sequence();
			end else if (r < 75) begin
				push_beat(any_byte(), 1'b0);
			end else if (r < 83) begin
				push_beat(any_byte(), 1'b1);
			end else begin
				push_beat(CH_ESC, 1'b0);
				repeat ($urandom_range(1, 4))
					push_beat(escape_alphabet_byte(), 1'b0);
			end
		end
	endfunction

	// Extremes, arrow, tilde, shifted-arrow and shifted-return keys, timeouts and a restart after a bad sequence.
	function automatic void load_directed();
		push_beat(8'h00, 1'b0);
		push_beat(8'hFF, 1'b0);
		push_beat(any_byte(), 1'b1);
		push_beat(CH_ESC, 1'b0);
		push_beat(any_byte(), 1'b1);
		push_beat(CH_ESC, 1'b0);
		push_beat(CH_LBRK, 1'b0);
		push_beat(CH_A, 1'b0);
		push_beat(CH_ESC, 1'b0);
		push_beat(CH_O, 1'b0);
		push_beat(CH_A, 1'b0);
		push_beat(CH_LBRK, 1'b0);
		push_beat(byte_t'(CH_A + 1), 1'b0);
		push_beat(CH_ESC, 1'b0);
		push_beat(CH_LBRK, 1'b0);
		push_beat(CH_5, 1'b0);
		push_beat(CH_TILDE, 1'b0);
		push_beat(CH_ESC, 1'b0);
		push_beat(CH_LBRK, 1'b0);
		push_beat(CH_1, 1'b0);
		push_beat(CH_SEMI, 1'b0);
		push_beat(CH_2, 1'b0);
		push_beat(CH_D, 1'b0);
		push_beat(CH_ESC, 1'b0);
		push_beat(CH_LBRK, 1'b0);
		push_beat(CH_1, 1'b0);
		push_beat(CH_3, 1'b0);
		push_beat(CH_SEMI, 1'b0);
		push_beat(CH_2, 1'b0);
		push_beat(CH_U, 1'b0);
	endfunction

	// Offers one input beat, after a random gap when input gaps are on, and waits for it to be taken.
	// Called and returning at a falling edge.
	task automatic send_beat(key_beat_t beat);
		int gap;
		gap = tx_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		byte_value <= beat.value;
		timed_out  <= beat.tick;
		in_valid   <= 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic send_all();
		while (stim_q.size() > 0)
			send_beat(stim_q.pop_front());
	endtask

	// Stops offering until every expected key code has come out.
	task automatic drain_pause();
		in_valid <= 1'b0;
		do @(negedge clk); while (tracker.outstanding() != 0);
	endtask

	// Output side: random gaps per result when output gaps are on, and a long hold-off on request.
	initial begin
		int gap;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (hold_request) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_request = 1'b0;
				holds_done++;
			end else begin
				gap = rx_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
				if (gap > 0) begin
					out_ready <= 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	// Beat monitor on both channels.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				tracker.note_beat(byte_value, timed_out);
			if (out_valid && out_ready)
				tracker.check_key(key_code);
		end
	end

	// Watchdog: ends the run when no beat moves on either side for too long.
	initial begin
		int quiet;
		quiet = 0;
		wait (arst_n === 1'b1);
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Timeout: no beat moved for %0d cycles.", STALL_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

	// Main sequence of test phases.
	initial begin
		tracker    = new();
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		byte_value = 8'h00;
		timed_out  = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed sequences, then a full drain.
		load_directed();
		send_all();
		drain_pause();

		// A stretch with no idling on either side.
		tx_gaps_on = 1'b0;
		rx_gaps_on = 1'b0;
		gen_random(100);
		send_all();
		tx_gaps_on = 1'b1;
		rx_gaps_on = 1'b1;

		// Output held off while the input keeps offering beats back to back.
		hold_request = 1'b1;
		tx_gaps_on   = 1'b0;
		gen_random(60);
		send_all();
		tx_gaps_on = 1'b1;

		// Random traffic with idling, split by a drain pause.
		gen_random(230);
		send_all();
		drain_pause();
		gen_random(230);
		send_all();

		// Let the pipeline empty and watch for stray results.
		in_valid <= 1'b0;
		while (tracker.outstanding() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Run covered %0d input beats and %0d key codes, %0d of them special keys.",
			tracker.beats_seen, tracker.keys_checked, tracker.special_keys);
		$display("Long output hold-offs: %0d; mismatches: %0d.", holds_done, tracker.errors);
		if (tracker.errors == 0 && tracker.outstanding() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl
rtl/tked_pkg.sv
rtl/terminal_key_escape_decoder_top.sv
test/tb.sv
